// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property check, disabled while reset is asserted
`ifndef SYNTHESIS
`define STRD_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("strd assertion failed");
`define STRD_ASSERT_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("strd forbidden condition seen");
`else
`define STRD_ASSERT(name, clk, rst_n, prop)
`define STRD_ASSERT_NEVER(name, clk, rst_n, expr)
`endif

`endif

// ===== rtl/strd_pkg.sv =====
package strd_pkg;

    typedef logic signed [23:0] t_s24;
    typedef logic [2:0]         t_mode;
    typedef logic [2:0]         t_cfg_idx;

    localparam t_mode MODE_OFF      = 3'd0;
    localparam t_mode MODE_NORMAL   = 3'd1;
    localparam t_mode MODE_MAX_HOLD = 3'd2;
    localparam t_mode MODE_MIN_HOLD = 3'd3;
    localparam t_mode MODE_MIN_MAX  = 3'd4;
    localparam t_mode MODE_AVG10    = 3'd5;
    localparam t_mode MODE_AVG100   = 3'd6;

    localparam t_cfg_idx CFG_MODE   = 3'd0;
    localparam t_cfg_idx CFG_ENABLE = 3'd1;
    localparam t_cfg_idx CFG_BINS   = 3'd2;
    localparam t_cfg_idx CFG_START  = 3'd3;
    localparam t_cfg_idx CFG_WIDTH  = 3'd4;

    localparam int CFG_DATA_W = 36;
    localparam int FREQ_W     = 36;
    localparam int BWID_W     = 32;
    localparam int BINS_W     = 11;
    localparam int OUT_IDX_W  = 10;

    // q16 averaging weights
    localparam logic signed [16:0] W10_OLD  = 17'sd58982;
    localparam logic signed [16:0] W10_NEW  = 17'sd6554;
    localparam logic signed [16:0] W100_OLD = 17'sd64881;
    localparam logic signed [16:0] W100_NEW = 17'sd655;

    localparam t_s24 PEAK_FLOOR = -24'sd256000;
    localparam t_s24 S24_MAX    = 24'sh7fffff;
    localparam t_s24 S24_MIN    = -24'sh800000;

    typedef struct packed {
        logic valid;
        logic last;
        logic active;
    } t_ctl;

endpackage

// ===== rtl/strd_in_if.sv =====
interface strd_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] sweep_min;
    logic signed [23:0] sweep_max;

    modport source (output valid, sweep_min, sweep_max, input ready);
    modport sink   (input valid, sweep_min, sweep_max, output ready);
endinterface

// ===== rtl/strd_out_if.sv =====
interface strd_out_if;
    logic               valid;
    logic               ready;
    logic [9:0]         bin_index;
    logic signed [23:0] trace_min;
    logic signed [23:0] trace_max;
    logic               trace_active;
    logic               last_bin;
    logic signed [23:0] peak_amp;
    logic [9:0]         peak_bin;
    logic [35:0]        peak_freq;

    modport source (output valid, bin_index, trace_min, trace_max, trace_active, last_bin,
                    peak_amp, peak_bin, peak_freq, input ready);
    modport sink   (input valid, bin_index, trace_min, trace_max, trace_active, last_bin,
                    peak_amp, peak_bin, peak_freq, output ready);
endinterface

// ===== rtl/spectrum_trace_detector.sv =====
// channel  | dir | payload
// i_in     | in  | sweep_min, sweep_max (one bin per transfer)
// o_out    | out | bin_index, trace_min, trace_max, trace_active, last_bin,
//          |     | peak_amp, peak_bin, peak_freq
// one bin per cycle unless o_out stalls; a result passes r1, s2, r3, r4, r5 and out
// the throughput is set by the single read-modify-write of the trace memory per bin
// a stall on o_out holds the whole pipeline, i_in included
// reset is synchronous; trace memory contents are undefined until a full sweep
// has written them, so there is no clearing pass
`include "assert_macros.svh"

module spectrum_trace_detector import strd_pkg::*; #(
    parameter int MAX_BINS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    strd_in_if.sink               i_in,
    strd_out_if.source            o_out
);

    localparam int IW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int LW = ((IW + 1) > BINS_W) ? (IW + 1) : BINS_W;

    t_mode              r_mode;
    logic               r_enable;
    logic [BINS_W-1:0]  r_bins;
    logic [FREQ_W-1:0]  r_start;
    logic [BWID_W-1:0]  r_width;

    logic [IW-1:0]      r_cnt;
    logic               r_primed;

    t_ctl               r1_ctl;
    logic [IW-1:0]      r1_idx;
    logic               r1_primed;
    t_s24               r1_new_min, r1_new_max;

    logic               adv;
    logic               accept;
    logic               restart;
    logic               last;
    logic [LW-1:0]      len, lim;
    logic [47:0]        rd_data;

    t_ctl               s2_ctl;
    logic [IW-1:0]      s2_idx;
    t_s24               s2_min, s2_max;

    assign adv     = !o_out.valid || o_out.ready;
    assign accept  = i_in.valid && adv;
    assign restart = i_cfg_we && ((i_cfg_idx == CFG_MODE) || (i_cfg_idx == CFG_BINS));

    assign i_in.ready = adv;

    always_comb begin
        len = LW'(r_bins);
        if (len < LW'(2)) begin
            len = LW'(2);
        end else if (len > LW'(MAX_BINS)) begin
            len = LW'(MAX_BINS);
        end
        lim  = len - LW'(1);
        last = LW'(r_cnt) >= lim;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_OFF;
            r_enable <= 1'b1;
            r_bins   <= BINS_W'(1024);
            r_start  <= '0;
            r_width  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:   r_mode   <= i_cfg_data[2:0];
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                CFG_BINS:   r_bins   <= i_cfg_data[BINS_W-1:0];
                CFG_START:  r_start  <= i_cfg_data[FREQ_W-1:0];
                CFG_WIDTH:  r_width  <= i_cfg_data[BWID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_primed <= 1'b0;
            r1_ctl   <= '0;
        end else begin
            if (restart) begin
                r_cnt    <= '0;
                r_primed <= 1'b0;
            end else if (accept && r_enable) begin
                if (last) begin
                    r_cnt    <= '0;
                    r_primed <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + IW'(1);
                end
            end
            if (adv) begin
                r1_ctl.valid  <= accept && r_enable;
                r1_ctl.last   <= last;
                r1_ctl.active <= (r_mode >= MODE_NORMAL) && (r_mode <= MODE_AVG100);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_idx     <= r_cnt;
            r1_primed  <= r_primed;
            r1_new_min <= i_in.sweep_min;
            r1_new_max <= i_in.sweep_max;
        end
    end

    strd_ram #(
        .DEPTH (MAX_BINS),
        .AW    (IW),
        .DW    (48)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (adv),
        .i_rd_addr (r_cnt),
        .i_wr_en   (adv && s2_ctl.valid),
        .i_wr_addr (s2_idx),
        .i_wr_data ({s2_min, s2_max}),
        .o_rd_data (rd_data)
    );

    strd_blend #(
        .IDX_W (IW)
    ) u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_mode    (r_mode),
        .i_ctl     (r1_ctl),
        .i_idx     (r1_idx),
        .i_primed  (r1_primed),
        .i_new_min (r1_new_min),
        .i_new_max (r1_new_max),
        .i_ram_min (rd_data[47:24]),
        .i_ram_max (rd_data[23:0]),
        .o_ctl     (s2_ctl),
        .o_idx     (s2_idx),
        .o_min     (s2_min),
        .o_max     (s2_max)
    );

    strd_peak #(
        .IDX_W (IW)
    ) u_peak (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_restart    (restart),
        .i_ctl        (s2_ctl),
        .i_idx        (s2_idx),
        .i_min        (s2_min),
        .i_max        (s2_max),
        .i_start_freq (r_start),
        .i_bin_width  (r_width),
        .o_out        (o_out)
    );

    // bin counter never passes the end of the sweep
    `STRD_ASSERT(a_cnt_in_sweep, i_clk, i_rst_n, LW'(r_cnt) <= lim)
    // neighboring pipeline items never touch the same bin, so one bypass path is enough
    `STRD_ASSERT_NEVER(a_no_adjacent_bin, i_clk, i_rst_n,
        r1_ctl.valid && s2_ctl.valid && (r1_idx == s2_idx))
    // peak fields are zero except on the last bin
    `STRD_ASSERT(a_peak_only_last, i_clk, i_rst_n,
        (o_out.valid && !o_out.last_bin) |-> ((o_out.peak_amp == '0) && (o_out.peak_bin == '0) && (o_out.peak_freq == '0)))

endmodule

// ===== rtl/strd_ram.sv =====
module strd_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 48
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd;

    // write-first: a read of the entry written in the same cycle sees the new data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd <= i_wr_data;
            end else begin
                r_rd <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd;

endmodule

// ===== rtl/strd_blend.sv =====
module strd_blend import strd_pkg::*; #(
    parameter int IDX_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  t_mode            i_mode,
    input  t_ctl             i_ctl,
    input  logic [IDX_W-1:0] i_idx,
    input  logic             i_primed,
    input  t_s24             i_new_min,
    input  t_s24             i_new_max,
    input  t_s24             i_ram_min,
    input  t_s24             i_ram_max,
    output t_ctl             o_ctl,
    output logic [IDX_W-1:0] o_idx,
    output t_s24             o_min,
    output t_s24             o_max
);

    t_s24               old_min, old_max;
    t_s24               sel_min, sel_max;
    t_s24               lo, hi;
    logic               is_avg;
    logic signed [16:0] w_old, w_new;

    t_ctl               r_ctl;
    logic [IDX_W-1:0]   r_idx;
    t_s24               r_sel_min, r_sel_max;
    logic               r_avg;
    logic signed [40:0] r_po_min, r_pn_min, r_po_max, r_pn_max;

    logic signed [42:0] sum_min, sum_max;
    logic signed [42:0] q_min, q_max;

    function automatic t_s24 sat24(input logic signed [42:0] v);
        t_s24 res;
        if (v > 43'(S24_MAX)) begin
            res = S24_MAX;
        end else if (v < 43'(S24_MIN)) begin
            res = S24_MIN;
        end else begin
            res = v[23:0];
        end
        return res;
    endfunction

    // before the first full sweep the stored entry counts as the input
    always_comb begin
        old_min = i_primed ? i_ram_min : i_new_min;
        old_max = i_primed ? i_ram_max : i_new_max;
        lo      = (old_min < i_new_min) ? old_min : i_new_min;
        hi      = (old_max > i_new_max) ? old_max : i_new_max;
        is_avg  = (i_mode == MODE_AVG10) || (i_mode == MODE_AVG100);
        w_old   = (i_mode == MODE_AVG10) ? W10_OLD : W100_OLD;
        w_new   = (i_mode == MODE_AVG10) ? W10_NEW : W100_NEW;
        case (i_mode)
            MODE_NORMAL: begin
                sel_min = i_new_min;
                sel_max = i_new_max;
            end
            MODE_MAX_HOLD: begin
                sel_min = hi;
                sel_max = hi;
            end
            MODE_MIN_HOLD: begin
                sel_min = lo;
                sel_max = lo;
            end
            MODE_MIN_MAX: begin
                sel_min = lo;
                sel_max = hi;
            end
            default: begin
                sel_min = old_min;
                sel_max = old_max;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_idx     <= i_idx;
            r_sel_min <= sel_min;
            r_sel_max <= sel_max;
            r_avg     <= is_avg;
            r_po_min  <= 41'(old_min) * 41'(w_old);
            r_pn_min  <= 41'(i_new_min) * 41'(w_new);
            r_po_max  <= 41'(old_max) * 41'(w_old);
            r_pn_max  <= 41'(i_new_max) * 41'(w_new);
        end
    end

    // round to nearest, floor shift, saturate
    always_comb begin
        sum_min = 43'(r_po_min) + 43'(r_pn_min) + 43'sd32768;
        sum_max = 43'(r_po_max) + 43'(r_pn_max) + 43'sd32768;
        q_min   = sum_min >>> 16;
        q_max   = sum_max >>> 16;
    end

    assign o_ctl = r_ctl;
    assign o_idx = r_idx;
    assign o_min = r_avg ? sat24(q_min) : r_sel_min;
    assign o_max = r_avg ? sat24(q_max) : r_sel_max;

endmodule

// ===== rtl/strd_peak.sv =====
module strd_peak import strd_pkg::*; #(
    parameter int IDX_W = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_restart,
    input  t_ctl                  i_ctl,
    input  logic [IDX_W-1:0]      i_idx,
    input  t_s24                  i_min,
    input  t_s24                  i_max,
    input  logic [FREQ_W-1:0]     i_start_freq,
    input  logic [BWID_W-1:0]     i_bin_width,
    strd_out_if.source            o_out
);

    localparam int PW = IDX_W + BWID_W;
    localparam int SW = ((PW > FREQ_W) ? PW : FREQ_W) + 1;

    t_ctl              r3_ctl, r4_ctl, r5_ctl, r_out_ctl;
    logic [IDX_W-1:0]  r3_idx, r4_idx, r5_idx;
    t_s24              r3_min, r3_max, r4_min, r4_max, r5_min, r5_max;
    t_s24              r4_pamp, r5_pamp;
    logic [IDX_W-1:0]  r4_pbin, r5_pbin;
    logic [PW-1:0]     r5_prod;

    t_s24              r_run_amp;
    logic [IDX_W-1:0]  r_run_bin;

    logic              hit;
    t_s24              cur_amp;
    logic [IDX_W-1:0]  cur_bin;
    logic [PW-1:0]     prod;
    logic [SW-1:0]     sum;
    logic [FREQ_W-1:0] freq;

    logic [OUT_IDX_W-1:0] r_o_idx, r_o_pbin;
    t_s24                 r_o_min, r_o_max, r_o_pamp;
    logic [FREQ_W-1:0]    r_o_freq;

    always_comb begin
        hit     = r3_max > r_run_amp;
        cur_amp = hit ? r3_max : r_run_amp;
        cur_bin = hit ? r3_idx : r_run_bin;
        prod    = PW'(r4_pbin) * PW'(i_bin_width);
        sum     = SW'(i_start_freq) + SW'(r5_prod);
        freq    = (|sum[SW-1:FREQ_W]) ? '1 : sum[FREQ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl    <= '0;
            r4_ctl    <= '0;
            r5_ctl    <= '0;
            r_out_ctl <= '0;
            r_run_amp <= PEAK_FLOOR;
            r_run_bin <= '0;
        end else begin
            if (i_restart) begin
                r_run_amp <= PEAK_FLOOR;
                r_run_bin <= '0;
            end else if (i_adv && r3_ctl.valid) begin
                if (r3_ctl.last) begin
                    r_run_amp <= PEAK_FLOOR;
                    r_run_bin <= '0;
                end else begin
                    r_run_amp <= cur_amp;
                    r_run_bin <= cur_bin;
                end
            end
            if (i_adv) begin
                r3_ctl    <= i_ctl;
                r4_ctl    <= r3_ctl;
                r5_ctl    <= r4_ctl;
                r_out_ctl <= r5_ctl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_idx   <= i_idx;
            r3_min   <= i_min;
            r3_max   <= i_max;
            r4_idx   <= r3_idx;
            r4_min   <= r3_min;
            r4_max   <= r3_max;
            r4_pamp  <= r3_ctl.last ? cur_amp : '0;
            r4_pbin  <= r3_ctl.last ? cur_bin : '0;
            r5_idx   <= r4_idx;
            r5_min   <= r4_min;
            r5_max   <= r4_max;
            r5_pamp  <= r4_pamp;
            r5_pbin  <= r4_pbin;
            r5_prod  <= prod;
            r_o_idx  <= OUT_IDX_W'(r5_idx);
            r_o_min  <= r5_min;
            r_o_max  <= r5_max;
            r_o_pamp <= r5_pamp;
            r_o_pbin <= OUT_IDX_W'(r5_pbin);
            r_o_freq <= r5_ctl.last ? freq : '0;
        end
    end

    assign o_out.valid        = r_out_ctl.valid;
    assign o_out.bin_index    = r_o_idx;
    assign o_out.trace_min    = r_o_min;
    assign o_out.trace_max    = r_o_max;
    assign o_out.trace_active = r_out_ctl.active;
    assign o_out.last_bin     = r_out_ctl.last;
    assign o_out.peak_amp     = r_o_pamp;
    assign o_out.peak_bin     = r_o_pbin;
    assign o_out.peak_freq    = r_o_freq;

endmodule

// ===== tb/tb_trace_pkg.sv =====
package tb_trace_pkg;
    import strd_pkg::*;

    localparam int TRACE_DEPTH = 1024;

    typedef logic signed [36:0] t_report_val;

    typedef struct packed {
        logic [9:0]  bin_index;
        t_s24        trace_min;
        t_s24        trace_max;
        logic        trace_active;
        logic        last_bin;
        t_s24        peak_amp;
        logic [9:0]  peak_bin;
        logic [35:0] peak_freq;
    } t_bin_result;

    class trace_checker;
        t_s24        min_store [TRACE_DEPTH];
        t_s24        max_store [TRACE_DEPTH];
        int unsigned bin_pos;
        bit          primed;
        t_s24        peak_amp;
        int unsigned peak_bin;

        t_mode       mode;
        bit          enabled;
        int unsigned bins_cfg;
        logic [35:0] start_hz;
        logic [31:0] step_hz;

        t_bin_result pending_bins [$];
        int          errors;

        function new();
            mode     = MODE_OFF;
            enabled  = 1'b1;
            bins_cfg = 1024;
            start_hz = '0;
            step_hz  = '0;
            errors   = 0;
            restart_sweep();
        endfunction

        function void restart_sweep();
            primed   = 1'b0;
            bin_pos  = 0;
            peak_amp = PEAK_FLOOR;
            peak_bin = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MODE: begin
                    mode = t_mode'(data[2:0]);
                    restart_sweep();
                end
                CFG_ENABLE: enabled = data[0];
                CFG_BINS: begin
                    bins_cfg = 32'(data[BINS_W-1:0]);
                    restart_sweep();
                end
                CFG_START: start_hz = data[FREQ_W-1:0];
                CFG_WIDTH: step_hz = data[BWID_W-1:0];
                default: ;
            endcase
        endfunction

        function t_s24 clip24(longint v);
            if (v > longint'(S24_MAX)) return S24_MAX;
            if (v < longint'(S24_MIN)) return S24_MIN;
            return t_s24'(v);
        endfunction

        // q16 weighted sum, round half up, then floor by arithmetic shift
        function t_s24 blend(t_s24 prev, t_s24 fresh, longint w_prev, longint w_new);
            longint s;
            s = longint'(prev) * w_prev + longint'(fresh) * w_new + 64'sd32768;
            return clip24(s >>> 16);
        endfunction

        function int pending();
            return pending_bins.size();
        endfunction

        function void note_bin(t_s24 nmin, t_s24 nmax);
            int unsigned len;
            int unsigned idx;
            bit          at_end;
            t_s24        omin;
            t_s24        omax;
            t_s24        rmin;
            t_s24        rmax;
            logic [63:0] freq;
            t_bin_result r;
            if (!enabled) return;
            len = (bins_cfg < 2) ? 2 : ((bins_cfg > TRACE_DEPTH) ? TRACE_DEPTH : bins_cfg);
            idx = bin_pos;
            at_end = (idx >= len - 1);
            if (idx >= TRACE_DEPTH) idx = TRACE_DEPTH - 1;
            omin = primed ? min_store[idx] : nmin;
            omax = primed ? max_store[idx] : nmax;
            case (mode)
                MODE_NORMAL: begin
                    rmin = nmin;
                    rmax = nmax;
                end
                MODE_MAX_HOLD: begin
                    rmax = (omax > nmax) ? omax : nmax;
                    rmin = rmax;
                end
                MODE_MIN_HOLD: begin
                    rmin = (omin < nmin) ? omin : nmin;
                    rmax = rmin;
                end
                MODE_MIN_MAX: begin
                    rmin = (omin < nmin) ? omin : nmin;
                    rmax = (omax > nmax) ? omax : nmax;
                end
                MODE_AVG10: begin
                    rmin = blend(omin, nmin, W10_OLD, W10_NEW);
                    rmax = blend(omax, nmax, W10_OLD, W10_NEW);
                end
                MODE_AVG100: begin
                    rmin = blend(omin, nmin, W100_OLD, W100_NEW);
                    rmax = blend(omax, nmax, W100_OLD, W100_NEW);
                end
                default: begin
                    rmin = omin;
                    rmax = omax;
                end
            endcase
            min_store[idx] = rmin;
            max_store[idx] = rmax;
            if (rmax > peak_amp) begin
                peak_amp = rmax;
                peak_bin = idx;
            end
            r = '0;
            r.bin_index    = 10'(idx);
            r.trace_min    = rmin;
            r.trace_max    = rmax;
            r.trace_active = (mode >= MODE_NORMAL) && (mode <= MODE_AVG100);
            r.last_bin     = at_end;
            if (at_end) begin
                freq = 64'(start_hz) + 64'(peak_bin) * 64'(step_hz);
                if (freq > 64'hF_FFFF_FFFF) freq = 64'hF_FFFF_FFFF;
                r.peak_amp  = peak_amp;
                r.peak_bin  = 10'(peak_bin);
                r.peak_freq = freq[35:0];
                restart_sweep();
                primed = 1'b1;
            end else begin
                bin_pos = idx + 1;
            end
            pending_bins = {pending_bins, r};
        endfunction

        function void report(string field, t_report_val want_v, t_report_val got_v);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
            errors++;
        endfunction

        function void check_bin(t_bin_result got);
            t_bin_result want;
            if (pending_bins.size() == 0) begin
                $display("%0t: unexpected result for bin %0d", $time, got.bin_index);
                errors++;
                return;
            end
            want = pending_bins.pop_front();
            if (got.bin_index !== want.bin_index)
                report("bin_index", want.bin_index, got.bin_index);
            if (got.trace_min !== want.trace_min)
                report("trace_min", want.trace_min, got.trace_min);
            if (got.trace_max !== want.trace_max)
                report("trace_max", want.trace_max, got.trace_max);
            if (got.trace_active !== want.trace_active)
                report("trace_active", want.trace_active, got.trace_active);
            if (got.last_bin !== want.last_bin)
                report("last_bin", want.last_bin, got.last_bin);
            if (got.peak_amp !== want.peak_amp)
                report("peak_amp", want.peak_amp, got.peak_amp);
            if (got.peak_bin !== want.peak_bin)
                report("peak_bin", want.peak_bin, got.peak_bin);
            if (got.peak_freq !== want.peak_freq)
                report("peak_freq", want.peak_freq, got.peak_freq);
        endfunction
    endclass

endpackage

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import strd_pkg::*;
    import tb_trace_pkg::*;

    localparam int RANDOM_BINS    = 600;
    localparam int SETTLE_CYCLES  = 10;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    t_cfg_idx              i_cfg_idx = CFG_MODE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    strd_in_if  i_in ();
    strd_out_if o_out ();

    trace_checker sb;
    logic         steady = 1'b0;
    logic         hold_go = 1'b0;
    int           hold_left = 0;
    int           idle_cycles = 0;

    spectrum_trace_detector u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_out      (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_go    <= 1'b0;
            hold_left  <= LONG_HOLD;
            o_out.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            o_out.ready <= 1'b0;
        end else begin
            o_out.ready <= steady || ($urandom_range(99) >= 12);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_bin_result got;
        bit          moved;
        moved = 1'b0;
        if (i_rst_n && i_in.valid && i_in.ready) begin
            sb.note_bin(i_in.sweep_min, i_in.sweep_max);
            moved = 1'b1;
        end
        if (i_rst_n && o_out.valid && o_out.ready) begin
            got.bin_index    = o_out.bin_index;
            got.trace_min    = o_out.trace_min;
            got.trace_max    = o_out.trace_max;
            got.trace_active = o_out.trace_active;
            got.last_bin     = o_out.last_bin;
            got.peak_amp     = o_out.peak_amp;
            got.peak_bin     = o_out.peak_bin;
            got.peak_freq    = o_out.peak_freq;
            sb.check_bin(got);
            moved = 1'b1;
        end
        if (moved) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("tb_top: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_s24 pick_level();
        int v;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: return S24_MIN;
                    1: return S24_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2: return t_s24'($urandom());
            default: begin
                v = int'($urandom_range(200000)) - 180000;
                return t_s24'(v);
            end
        endcase
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        sb.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    // drop valid, wait for every expected result, then let the pipeline empty
    task automatic quiesce();
        i_in.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_bin(t_s24 mn, t_s24 mx);
        while (!steady && $urandom_range(99) < 12) begin
            i_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in.valid     <= 1'b1;
        i_in.sweep_min <= mn;
        i_in.sweep_max <= mx;
        @(posedge i_clk);
        while (!i_in.ready) @(posedge i_clk);
    endtask

    task automatic set_mode(t_mode m);
        quiesce();
        write_reg(CFG_MODE, CFG_DATA_W'(m));
        i_cfg_we <= 1'b0;
    endtask

    // items sent while frozen must leave no trace
    task automatic frozen_burst();
        quiesce();
        write_reg(CFG_ENABLE, '0);
        i_cfg_we <= 1'b0;
        repeat ($urandom_range(1, 3)) send_bin(pick_level(), pick_level());
        quiesce();
        write_reg(CFG_ENABLE, CFG_DATA_W'(1));
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(int len_cfg, int n, bit pressure);
        logic [35:0] start_v;
        logic [31:0] width_v;
        int          freeze_at;
        quiesce();
        case ($urandom_range(3))
            0: start_v = '0;
            1: start_v = '1;
            default: start_v = {4'($urandom_range(15)), 32'($urandom())};
        endcase
        case ($urandom_range(3))
            0: width_v = '0;
            1: width_v = '1;
            2: width_v = $urandom();
            default: width_v = $urandom_range(100000);
        endcase
        write_reg(CFG_START, start_v);
        write_reg(CFG_WIDTH, CFG_DATA_W'(width_v));
        write_reg(CFG_MODE, CFG_DATA_W'($urandom_range(7)));
        write_reg(CFG_BINS, CFG_DATA_W'(len_cfg));
        i_cfg_we <= 1'b0;
        if (pressure) begin
            hold_go <= 1'b1;
            n += 40;
        end
        freeze_at = ($urandom_range(3) == 0) ? int'($urandom_range(n - 1)) : -1;
        for (int i = 0; i < n; i++) begin
            if (i == freeze_at) frozen_burst();
            send_bin(pick_level(), pick_level());
        end
    endtask

    initial begin
        int random_sent;
        int phase_no;
        int len_cfg;
        int len;
        int n;
        sb = new();
        i_in.valid     = 1'b0;
        i_in.sweep_min = '0;
        i_in.sweep_max = '0;
        o_out.ready    = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // normal copy, extremes, then a sweep that never beats the peak floor
        write_reg(CFG_START, 36'h1_2345_6789);
        write_reg(CFG_WIDTH, CFG_DATA_W'(1000));
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_NORMAL));
        write_reg(CFG_BINS, '0);
        i_cfg_we <= 1'b0;
        send_bin(S24_MIN, S24_MAX);
        send_bin(S24_MAX, S24_MIN);
        send_bin(-24'sd300000, -24'sd300000);
        send_bin(-24'sd256000, -24'sd256001);

        // max hold with saturating peak frequency, length register of one (clamped to two)
        quiesce();
        write_reg(CFG_START, '1);
        write_reg(CFG_WIDTH, CFG_DATA_W'(32'hFFFF_FFFF));
        write_reg(CFG_BINS, CFG_DATA_W'(1));
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_MAX_HOLD));
        i_cfg_we <= 1'b0;
        send_bin('0, -24'sd5);
        send_bin(24'sd100, 24'sd7);
        send_bin('0, S24_MAX);

        quiesce();
        write_reg(CFG_BINS, CFG_DATA_W'(2));
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_MIN_HOLD));
        i_cfg_we <= 1'b0;
        send_bin(24'sd5, S24_MAX);
        send_bin(S24_MIN, '0);
        send_bin('1, '0);

        set_mode(MODE_MIN_MAX);
        send_bin(-24'sd10, 24'sd10);
        send_bin(24'sd10, -24'sd10);
        send_bin(S24_MIN, S24_MAX);

        set_mode(MODE_AVG10);
        send_bin(S24_MAX, S24_MIN);
        send_bin(S24_MIN, S24_MAX);
        send_bin(S24_MIN, S24_MAX);

        set_mode(MODE_AVG100);
        send_bin(S24_MIN, S24_MAX);
        send_bin('0, '1);
        send_bin(S24_MAX, S24_MIN);

        // off stores the input until primed, then holds
        set_mode(MODE_OFF);
        send_bin(24'sd1, 24'sd2);
        send_bin(24'sd3, 24'sd4);
        send_bin(24'sd5, 24'sd6);

        set_mode(t_mode'(3'd7));
        send_bin(24'sd7, 24'sd8);
        send_bin(24'sd9, 24'sd10);

        quiesce();
        write_reg(CFG_ENABLE, '0);
        i_cfg_we <= 1'b0;
        send_bin(24'sd11, 24'sd12);
        quiesce();
        write_reg(CFG_ENABLE, CFG_DATA_W'(1));
        i_cfg_we <= 1'b0;

        random_sent = 0;
        phase_no = 0;
        while (random_sent < RANDOM_BINS) begin
            phase_no++;
            steady <= (phase_no >= 8 && phase_no <= 11);
            len_cfg = ($urandom_range(15) == 0) ? int'($urandom_range(1))
                                                : int'($urandom_range(2, 12));
            len = (len_cfg < 2) ? 2 : len_cfg;
            n = len * int'($urandom_range(1, 4)) + int'($urandom_range(len - 1));
            run_phase(len_cfg, n, phase_no == 3);
            random_sent += n;
        end
        steady <= 1'b0;

        // length register past its range
        run_phase(2047, 48, 1'b0);

        quiesce();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
